### rtl/core/etfp_pkg.sv
`default_nettype none

package etfp_pkg;

    // Sequencer states of the pixel engine.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_RE,
        ST_C_IM,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_AB,
        ST_UPDATE,
        ST_RR,
        ST_II,
        ST_TEST,
        ST_FINISH
    } state_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_CENTER_REAL     = 2'd0,
        REG_CENTER_IMAG     = 2'd1,
        REG_PIXEL_STEP      = 2'd2,
        REG_ITERATION_LIMIT = 2'd3
    } reg_index_t;

    localparam logic signed [31:0] CENTER_RESET     = 32'sd0;
    localparam logic [28:0]        STEP_RESET       = 29'd262144;
    localparam logic [20:0]        LIMIT_RESET      = 21'd96;
    localparam logic [20:0]        LIMIT_MIN        = 21'd2;
    // Escape radius squared, 4.0 in Q8.56.
    localparam logic [63:0]        ESCAPE_MAG       = 64'h0400_0000_0000_0000;
    localparam logic signed [63:0] Q428_MAX         = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Q428_MIN         = -64'sh0000_0000_8000_0000;

    // Clamp a wide signed value to the Q4.28 range.
    function automatic logic signed [31:0] sat_q428(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > Q428_MAX) begin
            r = Q428_MAX[31:0];
        end else if (x < Q428_MIN) begin
            r = Q428_MIN[31:0];
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/escape_time_fractal_pixel_unit.sv
// Flow: an accepted pixel passes the setup states C_RE, C_IM, SQ_RE, SQ_IM and AB,
// then the iteration loop, then FINISH, which waits until the output register can take it.
// The input is ready again once the result has moved into the output register, so
// the pixel rate is set by the iteration loop (UPDATE, RR, II, TEST) around the
// single shared 32x32 multiplier.
// Reset: aresetn is synchronous and active low; it clears the sequencer and the
// output valid, and loads the configuration registers with their reset values.
`default_nettype none

module escape_time_fractal_pixel_unit #(
    parameter int COLORMAP_SIZE = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // Input pixel stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [11:0] pixel_x, [23:12] pixel_y
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [20:0] iteration_count, [29:21] color_index, zero pad
    output logic             m_tuser    // [0] inside_set
);

    // Width of the running color counter that tracks count mod COLORMAP_SIZE.
    localparam int MW = (COLORMAP_SIZE > 1) ? $clog2(COLORMAP_SIZE) : 1;

    etfp_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic signed [31:0] center_real_reg;
    logic signed [31:0] center_imag_reg;
    logic [28:0]        pixel_step_reg;
    logic [20:0]        iteration_limit_reg;

    // Datapath registers.
    logic signed [11:0] px_reg, px_next;
    logic signed [11:0] py_reg, py_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] cr_reg, cr_next;
    logic signed [31:0] ci_reg, ci_next;
    logic signed [31:0] a_reg, a_next;
    logic signed [31:0] b_reg, b_next;
    logic signed [63:0] aa_reg, aa_next;
    logic signed [63:0] bb_reg, bb_next;
    logic [20:0]        count_reg, count_next;
    logic [MW-1:0]      mod_reg, mod_next;
    logic               inside_reg, inside_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [20:0] out_count_reg, out_count_next;
    logic        out_inside_reg, out_inside_next;
    logic [8:0]  out_color_reg, out_color_next;

    // Shared multiplier operands and product.
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [63:0] mult_full;

    logic [20:0]        lim_even;
    logic [20:0]        lim_eff;
    logic [20:0]        count_inc;
    logic [MW-1:0]      mod_inc;
    logic [MW:0]        mod_plus;
    logic [MW+8:0]      mod_ext;
    logic [63:0]        mag;
    logic               escaped;
    logic               reached;
    logic               can_load;
    logic signed [63:0] diff_sq;

    // Never stalls; the user must write only while the block is idle, which is not enforced.
    assign cfg_ready = 1'b1;

    // Odd limits round down, and anything below two counts as two.
    assign lim_even = {iteration_limit_reg[20:1], 1'b0};
    assign lim_eff  = (lim_even < etfp_pkg::LIMIT_MIN) ? etfp_pkg::LIMIT_MIN : lim_even;

    // One signed 32x32 multiply per cycle, always registered in prod_reg.
    assign mult_full = op_a * op_b;

    assign count_inc = count_reg + 21'd1;
    assign mod_plus  = {1'b0, mod_reg} + {{MW{1'b0}}, 1'b1};
    assign mod_inc   = (mod_plus == (MW+1)'(COLORMAP_SIZE)) ? '0 : mod_plus[MW-1:0];
    // The color counter widened so that its low nine bits can always be taken.
    assign mod_ext   = {9'd0, mod_reg};

    // In the test state prod_reg holds the new imaginary part squared and aa_reg
    // the new real part squared; both are non-negative, so the sum fits 64 bits.
    assign mag     = aa_reg + prod_reg;
    assign escaped = mag > etfp_pkg::ESCAPE_MAG;
    assign reached = count_inc >= lim_eff;
    assign diff_sq = aa_reg - bb_reg;

    // The output register takes a finished pixel when empty or being drained.
    assign can_load = !out_valid_reg || m_tready;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            etfp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = etfp_pkg::ST_C_RE;
                end
            end
            etfp_pkg::ST_C_RE:   state_next = etfp_pkg::ST_C_IM;
            etfp_pkg::ST_C_IM:   state_next = etfp_pkg::ST_SQ_RE;
            etfp_pkg::ST_SQ_RE:  state_next = etfp_pkg::ST_SQ_IM;
            etfp_pkg::ST_SQ_IM:  state_next = etfp_pkg::ST_AB;
            etfp_pkg::ST_AB:     state_next = etfp_pkg::ST_UPDATE;
            etfp_pkg::ST_UPDATE: state_next = etfp_pkg::ST_RR;
            etfp_pkg::ST_RR:     state_next = etfp_pkg::ST_II;
            etfp_pkg::ST_II:     state_next = etfp_pkg::ST_TEST;
            etfp_pkg::ST_TEST: begin
                // The limit is only looked at after an even number of iterations.
                if (escaped || (!count_inc[0] && reached)) begin
                    state_next = etfp_pkg::ST_FINISH;
                end else begin
                    state_next = etfp_pkg::ST_UPDATE;
                end
            end
            etfp_pkg::ST_FINISH: begin
                if (can_load) begin
                    state_next = etfp_pkg::ST_IDLE;
                end
            end
            default: state_next = etfp_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: input ready and multiplier operand selection.
    always_comb begin
        s_tready = 1'b0;
        op_a     = '0;
        op_b     = '0;
        case (state_reg)
            etfp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            etfp_pkg::ST_C_RE: begin
                op_a = {{20{px_reg[11]}}, px_reg};
                op_b = {3'b000, pixel_step_reg};
            end
            etfp_pkg::ST_C_IM: begin
                op_a = {{20{py_reg[11]}}, py_reg};
                op_b = {3'b000, pixel_step_reg};
            end
            etfp_pkg::ST_SQ_RE: begin
                op_a = cr_reg;
                op_b = cr_reg;
            end
            etfp_pkg::ST_SQ_IM: begin
                op_a = ci_reg;
                op_b = ci_reg;
            end
            etfp_pkg::ST_AB, etfp_pkg::ST_TEST: begin
                op_a = a_reg;
                op_b = b_reg;
            end
            etfp_pkg::ST_RR: begin
                op_a = a_reg;
                op_b = a_reg;
            end
            etfp_pkg::ST_II: begin
                op_a = b_reg;
                op_b = b_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Datapath next values. The product of each multiplying state is consumed in the next one.
    always_comb begin
        px_next         = px_reg;
        py_next         = py_reg;
        prod_next       = mult_full;
        cr_next         = cr_reg;
        ci_next         = ci_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        aa_next         = aa_reg;
        bb_next         = bb_reg;
        count_next      = count_reg;
        mod_next        = mod_reg;
        inside_next     = inside_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_count_next  = out_count_reg;
        out_inside_next = out_inside_reg;
        out_color_next  = out_color_reg;
        case (state_reg)
            etfp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    px_next    = s_tdata[11:0];
                    py_next    = s_tdata[23:12];
                    count_next = '0;
                    mod_next   = '0;
                end
            end
            etfp_pkg::ST_C_IM: begin
                cr_next = etfp_pkg::sat_q428(64'(center_real_reg) + prod_reg);
            end
            etfp_pkg::ST_SQ_RE: begin
                ci_next = etfp_pkg::sat_q428(64'(center_imag_reg) + prod_reg);
                a_next  = cr_reg;
            end
            etfp_pkg::ST_SQ_IM: begin
                aa_next = prod_reg;
                b_next  = ci_reg;
            end
            etfp_pkg::ST_AB: begin
                bb_next = prod_reg;
            end
            etfp_pkg::ST_UPDATE: begin
                // Real part from a*a - b*b, imaginary part 2ab from the a*b product.
                a_next = etfp_pkg::sat_q428((diff_sq >>> 28) + 64'(cr_reg));
                b_next = etfp_pkg::sat_q428((prod_reg >>> 27) + 64'(ci_reg));
            end
            etfp_pkg::ST_II: begin
                aa_next = prod_reg;
            end
            etfp_pkg::ST_TEST: begin
                bb_next     = prod_reg;
                count_next  = count_inc;
                mod_next    = mod_inc;
                inside_next = reached;
            end
            etfp_pkg::ST_FINISH: begin
                if (can_load) begin
                    out_valid_next  = 1'b1;
                    out_count_next  = count_reg;
                    out_inside_next = inside_reg;
                    out_color_next  = inside_reg ? 9'd0 : mod_ext[8:0];
                end
            end
            default: begin
                prod_next = mult_full;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= etfp_pkg::ST_IDLE;
            out_valid_reg       <= 1'b0;
            center_real_reg     <= etfp_pkg::CENTER_RESET;
            center_imag_reg     <= etfp_pkg::CENTER_RESET;
            pixel_step_reg      <= etfp_pkg::STEP_RESET;
            iteration_limit_reg <= etfp_pkg::LIMIT_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    etfp_pkg::REG_CENTER_REAL:     center_real_reg     <= cfg_data;
                    etfp_pkg::REG_CENTER_IMAG:     center_imag_reg     <= cfg_data;
                    etfp_pkg::REG_PIXEL_STEP:      pixel_step_reg      <= cfg_data[28:0];
                    etfp_pkg::REG_ITERATION_LIMIT: iteration_limit_reg <= cfg_data[20:0];
                    default:                       center_real_reg     <= center_real_reg;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        px_reg         <= px_next;
        py_reg         <= py_next;
        prod_reg       <= prod_next;
        cr_reg         <= cr_next;
        ci_reg         <= ci_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        aa_reg         <= aa_next;
        bb_reg         <= bb_next;
        count_reg      <= count_next;
        mod_reg        <= mod_next;
        inside_reg     <= inside_next;
        out_count_reg  <= out_count_next;
        out_inside_reg <= out_inside_next;
        out_color_reg  <= out_color_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_color_reg, out_count_reg};
    assign m_tuser  = out_inside_reg;

    // An inside pixel always reports color index zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[29:21] == 9'd0))
        else $error("inside pixel with nonzero color index");

    // A delivered count is at least one and never above the effective limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[20:0] != 21'd0) && (m_tdata[20:0] <= lim_eff)))
        else $error("iteration count out of range");

    // The loop never tests past the limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == etfp_pkg::ST_TEST) |-> (count_reg < lim_eff))
        else $error("iteration loop ran past the limit");

    // A pixel reaching its limit on an even count always leaves the loop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == etfp_pkg::ST_TEST) && reached && !count_inc[0])
        |=> (state_reg == etfp_pkg::ST_FINISH))
        else $error("loop did not stop at the limit");

endmodule

`default_nettype wire
